// File: design/sorted_priority_queue_top_defines.svh
// -----------------------------------------------------------------------------
// sorted priority queue assertion macros
// assertion forms used by the queue back end
// -----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/spq_pkg.sv
// -----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue modules
// -----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DATA_W          = 32;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;
    localparam int COUNT_OUT_W     = 5;
    localparam int FIFO_DEPTH      = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic              is_push;
        logic              is_pop;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] prio;
    } t_req;

endpackage

// File: design/spq_front.sv
// -----------------------------------------------------------------------------
// spq_front
// takes request items, classifies the opcode and buffers them in a short queue
// -----------------------------------------------------------------------------
module spq_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [spq_pkg::OP_W-1:0]    i_opcode,
    input  logic [spq_pkg::DATA_W-1:0]  i_item_value,
    input  logic [spq_pkg::DATA_W-1:0]  i_item_priority,
    output logic                        o_req_valid,
    input  logic                        i_req_take,
    output spq_pkg::t_req               o_req
);

    localparam int PW = $clog2(spq_pkg::FIFO_DEPTH);
    localparam int FW = $clog2(spq_pkg::FIFO_DEPTH + 1);

    spq_pkg::t_req r_slot [spq_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [FW-1:0] r_fill, n_fill;

    spq_pkg::t_req w_cls;
    logic          w_enq;
    logic          w_deq;

    // opcode three behaves as a peek
    always_comb begin
        w_cls.is_push = 1'b0;
        w_cls.is_pop  = 1'b0;
        w_cls.value   = i_item_value;
        w_cls.prio    = i_item_priority;
        unique case (i_opcode)
            spq_pkg::OP_PUSH: w_cls.is_push = 1'b1;
            spq_pkg::OP_POP:  w_cls.is_pop  = 1'b1;
            default:          ;
        endcase
    end

    assign o_in_ready  = (r_fill != FW'(spq_pkg::FIFO_DEPTH));
    assign w_enq       = i_in_valid && o_in_ready;
    assign o_req_valid = (r_fill != '0);
    assign w_deq       = i_req_take && o_req_valid;
    assign o_req       = r_slot[r_rd];

    always_comb begin
        n_wr   = w_enq ? PW'(r_wr + 1'b1) : r_wr;
        n_rd   = w_deq ? PW'(r_rd + 1'b1) : r_rd;
        n_fill = r_fill;
        if (w_enq && !w_deq) begin
            n_fill = FW'(r_fill + 1'b1);
        end else if (!w_enq && w_deq) begin
            n_fill = FW'(r_fill - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_slot[r_wr] <= w_cls;
        end
    end

endmodule

// File: design/spq_back.sv
// -----------------------------------------------------------------------------
// spq_back
// row of sorted cells that carries out push, pop and peek, plus result register
// -----------------------------------------------------------------------------
`include "sorted_priority_queue_top_defines.svh"

module spq_back #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_take,
    input  spq_pkg::t_req                  i_req,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [spq_pkg::DATA_W-1:0]     o_front_value,
    output logic [spq_pkg::DATA_W-1:0]     o_front_priority,
    output logic [spq_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_queue_empty,
    output logic [spq_pkg::COUNT_OUT_W-1:0] o_entry_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [spq_pkg::DATA_W-1:0] r_val  [QUEUE_DEPTH];
    logic [spq_pkg::DATA_W-1:0] r_prio [QUEUE_DEPTH];
    logic [CW-1:0]              r_count, n_count;

    logic [QUEUE_DEPTH-1:0] w_ge;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_take;
    logic                   w_ins;
    logic                   w_rem;

    logic [spq_pkg::DATA_W-1:0]   n_fv, n_fp;
    logic [spq_pkg::STATUS_W-1:0] n_st;

    logic                         r_out_valid;
    logic [spq_pkg::DATA_W-1:0]   r_out_fv, r_out_fp;
    logic [spq_pkg::STATUS_W-1:0] r_out_st;
    logic [CW-1:0]                r_out_count;

    assign w_full  = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);
    assign w_take  = i_req_valid && (!r_out_valid || i_out_ready);
    assign w_ins   = w_take && i_req.is_push && !w_full;
    assign w_rem   = w_take && i_req.is_pop && !w_empty;
    assign o_req_take = w_take;

    // each cell flags whether the new entry goes at or ahead of it;
    // empty cells count as behind, so the flags rise once along the row
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        assign w_ge[gi] = (CW'(gi) >= r_count) ||
                          ($signed(r_prio[gi]) >= $signed(i_req.prio));

        always_ff @(posedge i_clk) begin
            if (w_ins) begin
                if (gi > 0 && w_ge[(gi > 0) ? gi - 1 : 0]) begin
                    r_val[gi]  <= r_val[(gi > 0) ? gi - 1 : 0];
                    r_prio[gi] <= r_prio[(gi > 0) ? gi - 1 : 0];
                end else if (w_ge[gi]) begin
                    r_val[gi]  <= i_req.value;
                    r_prio[gi] <= i_req.prio;
                end
            end else if (w_rem && gi < QUEUE_DEPTH - 1) begin
                r_val[gi]  <= r_val[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
                r_prio[gi] <= r_prio[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = CW'(r_count + 1'b1);
        end else if (w_rem) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    // front entry reported with the result
    always_comb begin
        n_fv = r_val[0];
        n_fp = r_prio[0];
        n_st = spq_pkg::ST_OK;
        if (i_req.is_push) begin
            if (w_full) begin
                n_st = spq_pkg::ST_FULL;
            end else if (w_ge[0]) begin
                n_fv = i_req.value;
                n_fp = i_req.prio;
            end
        end else if (w_empty) begin
            n_fv = '0;
            n_fp = '0;
            n_st = spq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_fv    <= n_fv;
            r_out_fp    <= n_fp;
            r_out_st    <= n_st;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_front_value    = r_out_fv;
    assign o_front_priority = r_out_fp;
    assign o_status         = r_out_st;
    assign o_queue_empty    = (r_out_count == '0);
    assign o_entry_count    = spq_pkg::COUNT_OUT_W'(r_out_count);

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH), "count above depth")
    `SPQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_take && i_req.is_push && !w_full, r_count == CW'($past(r_count) + 1'b1), "push did not add an entry")
    `SPQ_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n, w_take && i_req.is_pop && !w_empty, r_count == CW'($past(r_count) - 1'b1), "pop did not remove an entry")
    `SPQ_ASSERT_NOW(a_full_count, i_clk, i_rst_n, r_out_valid && r_out_st == spq_pkg::ST_FULL, r_out_count == CW'(QUEUE_DEPTH), "full status with room left")

endmodule

// File: design/sorted_priority_queue_top.sv
// Sorted priority queue, lowest priority number first. Takes one request item
// per clock (push, pop or peek) while the output is not stalled, and returns
// one result item per request, in order: the front entry, a status, an empty
// flag and the entry count. A request waits in a two-entry queue before it
// reaches the cell row, and its result is registered when the row takes it.
// The cell row compares every held priority against the incoming one and
// shifts all cells at once, which sustains one request per clock when the
// output is not stalled.
// -----------------------------------------------------------------------------
// sorted_priority_queue_top
// top level joining the request front end and the sorted cell row
// -----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [spq_pkg::OP_W-1:0]        i_opcode,
    input  logic [spq_pkg::DATA_W-1:0]      i_item_value,
    input  logic [spq_pkg::DATA_W-1:0]      i_item_priority,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [spq_pkg::DATA_W-1:0]      o_front_value,
    output logic [spq_pkg::DATA_W-1:0]      o_front_priority,
    output logic [spq_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_queue_empty,
    output logic [spq_pkg::COUNT_OUT_W-1:0] o_entry_count
);

    logic          w_req_valid;
    logic          w_req_take;
    spq_pkg::t_req w_req;

    spq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_item_value   (i_item_value),
        .i_item_priority(i_item_priority),
        .o_req_valid    (w_req_valid),
        .i_req_take     (w_req_take),
        .o_req          (w_req)
    );

    spq_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (w_req_valid),
        .o_req_take      (w_req_take),
        .i_req           (w_req),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_front_value   (o_front_value),
        .o_front_priority(o_front_priority),
        .o_status        (o_status),
        .o_queue_empty   (o_queue_empty),
        .o_entry_count   (o_entry_count)
    );

endmodule

// File: bench/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted priority queue: drives push, pop and peek
// requests under random gaps and output back-pressure, predicts every result
// from a shadow copy of the sorted entries and compares it field by field
// -----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = spq_pkg::DEF_QUEUE_DEPTH;
    localparam int STALL_LIMIT    = 2000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int IDLE_PCT       = 26;

    // the fourth opcode behaves as a peek
    localparam logic [spq_pkg::OP_W-1:0] OP_PEEK_ALT = 2'd3;

    typedef struct packed {
        logic [spq_pkg::DATA_W-1:0]      value;
        logic [spq_pkg::DATA_W-1:0]      prio;
        logic [spq_pkg::STATUS_W-1:0]    status;
        logic                            empty;
        logic [spq_pkg::COUNT_OUT_W-1:0] count;
    } t_front_report;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_in_valid      = 1'b0;
    logic                            o_in_ready;
    logic [spq_pkg::OP_W-1:0]        i_opcode        = spq_pkg::OP_PUSH;
    logic [spq_pkg::DATA_W-1:0]      i_item_value    = '0;
    logic [spq_pkg::DATA_W-1:0]      i_item_priority = '0;
    logic                            o_out_valid;
    logic                            i_out_ready     = 1'b0;
    logic [spq_pkg::DATA_W-1:0]      o_front_value;
    logic [spq_pkg::DATA_W-1:0]      o_front_priority;
    logic [spq_pkg::STATUS_W-1:0]    o_status;
    logic                            o_queue_empty;
    logic [spq_pkg::COUNT_OUT_W-1:0] o_entry_count;

    // shadow of the sorted entries, slot 0 is the front
    logic signed [spq_pkg::DATA_W-1:0] held_value [DEPTH];
    logic signed [spq_pkg::DATA_W-1:0] held_prio  [DEPTH];
    int                                held_count = 0;

    t_front_report pending_reports[$];

    int  error_count    = 0;
    int  checked_count  = 0;
    int  quiet_cycles   = 0;
    int  in_idle_pct    = IDLE_PCT;
    int  out_idle_pct   = IDLE_PCT;
    bit  rx_hold_req    = 1'b0;
    int  n_push         = 0;
    int  n_pop          = 0;
    int  n_peek         = 0;
    int  n_full_drop    = 0;
    int  n_empty_err    = 0;
    int  peak_count     = 0;

    sorted_priority_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_front_value   (o_front_value),
        .o_front_priority(o_front_priority),
        .o_status        (o_status),
        .o_queue_empty   (o_queue_empty),
        .o_entry_count   (o_entry_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // applies one request to the shadow queue and returns the front report
    function automatic t_front_report serve_request(
        input logic [spq_pkg::OP_W-1:0]   op,
        input logic [spq_pkg::DATA_W-1:0] val,
        input logic [spq_pkg::DATA_W-1:0] pri);
        t_front_report rep;
        int            pos;
        rep    = '0;
        rep.status = spq_pkg::ST_OK;
        case (op)
            spq_pkg::OP_PUSH: begin
                n_push++;
                if (held_count >= DEPTH) begin
                    rep.status = spq_pkg::ST_FULL;
                    n_full_drop++;
                end else begin
                    // new entry goes ahead of equal priorities
                    pos = 0;
                    while (pos < held_count && held_prio[pos] < $signed(pri))
                        pos++;
                    for (int k = held_count; k > pos; k--) begin
                        held_value[k] = held_value[k-1];
                        held_prio[k]  = held_prio[k-1];
                    end
                    held_value[pos] = val;
                    held_prio[pos]  = pri;
                    held_count++;
                end
                if (held_count > 0) begin
                    rep.value = held_value[0];
                    rep.prio  = held_prio[0];
                end
            end
            spq_pkg::OP_POP: begin
                n_pop++;
                if (held_count == 0) begin
                    rep.status = spq_pkg::ST_EMPTY;
                    n_empty_err++;
                end else begin
                    rep.value = held_value[0];
                    rep.prio  = held_prio[0];
                    for (int k = 1; k < held_count; k++) begin
                        held_value[k-1] = held_value[k];
                        held_prio[k-1]  = held_prio[k];
                    end
                    held_count--;
                end
            end
            default: begin
                n_peek++;
                if (held_count == 0) begin
                    rep.status = spq_pkg::ST_EMPTY;
                    n_empty_err++;
                end else begin
                    rep.value = held_value[0];
                    rep.prio  = held_prio[0];
                end
            end
        endcase
        if (held_count > peak_count)
            peak_count = held_count;
        rep.empty = (held_count == 0);
        rep.count = held_count[spq_pkg::COUNT_OUT_W-1:0];
        return rep;
    endfunction

    task automatic send_item(input logic [spq_pkg::OP_W-1:0]   op,
                             input logic [spq_pkg::DATA_W-1:0] val,
                             input logic [spq_pkg::DATA_W-1:0] pri);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_item_value    <= val;
        i_item_priority <= pri;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_reports.push_back(serve_request(op, val, pri));
    endtask

    // sender stops offering until every outstanding result is back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_queue();
        send_item(spq_pkg::OP_POP, 32'h1234_5678, 32'h0000_0001);
        send_item(spq_pkg::OP_PEEK, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(OP_PEEK_ALT, 32'h0, 32'h7FFF_FFFF);
    endtask

    task automatic test_fill_and_overflow();
        logic [spq_pkg::DATA_W-1:0] pri;
        send_item(spq_pkg::OP_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(spq_pkg::OP_PUSH, 32'h8000_0000, 32'h8000_0000);
        send_item(spq_pkg::OP_PUSH, 32'h0000_0001, 32'h0000_0000);
        send_item(spq_pkg::OP_PUSH, 32'h0000_0002, 32'h0000_0000);
        send_item(spq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // ties at the head and at the tail
        send_item(spq_pkg::OP_PUSH, 32'h0000_0003, 32'h8000_0000);
        send_item(spq_pkg::OP_PUSH, 32'h0000_0004, 32'h7FFF_FFFF);
        for (int k = 0; k < DEPTH - 7; k++) begin
            pri = k * 3 - 10;
            send_item(spq_pkg::OP_PUSH, 32'h0000_0100 + k, pri);
        end
        // would become the front if it were not dropped
        send_item(spq_pkg::OP_PUSH, 32'hDEAD_BEEF, 32'h8000_0000);
        send_item(spq_pkg::OP_PEEK, 32'h0, 32'h0);
        send_item(OP_PEEK_ALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(spq_pkg::OP_POP, 32'h0, 32'h0);
    endtask

    task automatic test_random_traffic(input int n_items, input int push_pct);
        logic [spq_pkg::OP_W-1:0]   op;
        logic [spq_pkg::DATA_W-1:0] pri;
        int                         r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < push_pct)
                op = spq_pkg::OP_PUSH;
            else begin
                r = $urandom_range(9);
                op = (r < 6) ? spq_pkg::OP_POP : (r < 9) ? spq_pkg::OP_PEEK : OP_PEEK_ALT;
            end
            // mostly a narrow band so that ties are common
            case ($urandom_range(9))
                0: pri = $urandom();
                1: begin
                    case ($urandom_range(3))
                        0: pri = 32'h8000_0000;
                        1: pri = 32'h7FFF_FFFF;
                        2: pri = 32'h0000_0000;
                        default: pri = 32'hFFFF_FFFF;
                    endcase
                end
                default: pri = $urandom_range(12) - 6;
            endcase
            send_item(op, $urandom(), pri);
        end
    endtask

    task automatic test_burst_without_gaps();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_random_traffic(120, 50);
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    task automatic test_output_backpressure();
        in_idle_pct = 0;
        rx_hold_req = 1'b1;
        test_random_traffic(24, 60);
        in_idle_pct = IDLE_PCT;
        wait_for_results();
    endtask

    // result sink with random stalls and an occasional long hold-off
    always begin
        @(negedge i_clk);
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            i_out_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge i_clk);
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic [spq_pkg::DATA_W-1:0] want,
                                 input logic [spq_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_front_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                error_count++;
                $display("%0t: result item with nothing expected, value %0h priority %0h",
                         $time, o_front_value, o_front_priority);
            end else begin
                want = pending_reports.pop_front();
                checked_count++;
                compare_field("front_value", want.value, o_front_value);
                compare_field("front_priority", want.prio, o_front_priority);
                compare_field("status", spq_pkg::DATA_W'(want.status),
                              spq_pkg::DATA_W'(o_status));
                compare_field("queue_empty", spq_pkg::DATA_W'(want.empty),
                              spq_pkg::DATA_W'(o_queue_empty));
                compare_field("entry_count", spq_pkg::DATA_W'(want.count),
                              spq_pkg::DATA_W'(o_entry_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_and_overflow();
        wait_for_results();
        test_random_traffic(160, 55);
        test_burst_without_gaps();
        test_output_backpressure();
        test_random_traffic(150, 35);
        test_random_traffic(150, 70);

        wait_for_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d pushes (%0d dropped when full), %0d pops, %0d peeks, %0d on empty",
                 n_push, n_full_drop, n_pop, n_peek, n_empty_err);
        $display("peak occupancy %0d of %0d, %0d results checked, %0d mismatches",
                 peak_count, DEPTH, checked_count, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
